@@ hdl/pid_controller_anti_windup_defines.svh @@
// Assertion macros for the PID controller with integral clamp.
// Used by the top level only; no other dependencies.
`ifndef PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH

// same-cycle implication
`define PIDAW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidaw: assertion failed");

// next-cycle implication
`define PIDAW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidaw: assertion failed");

`endif

@@ hdl/pidaw_pkg.sv @@
// Package for the PID controller: item and register types, microcode
// types and the microprogram ROM. No dependencies.
`timescale 1ns / 1ps

package pidaw_pkg;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] measurement;
        logic        [15:0] delta_time;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [31:0] lim_lo;
        logic signed [31:0] lim_hi;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_LIM_LO  = 3'd3,
        REG_LIM_HI  = 3'd4
    } t_reg_idx;

    localparam logic signed [31:0] LIM_LO_RESET = -32'sd25600;
    localparam logic signed [31:0] LIM_HI_RESET = 32'sd25600;
    localparam logic signed [31:0] DRIVE_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DRIVE_MIN    = 32'sh8000_0000;

    // dividend is |error change| (17 bits) scaled by 2^12
    localparam int DIV_BITS = 29;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_ERR,
        OP_MUL,
        OP_INTEG,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_DIV_START,
        OP_DIV_SIGN,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        MS_ERR_DT,
        MS_P,
        MS_I,
        MS_D
    } t_msel;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_JUMP,
        JC_WAIT_IN,
        JC_DT_ZERO,
        JC_DIV_BUSY,
        JC_WAIT_OUT
    } t_jcond;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_op    op;
        t_msel  msel;
        t_jcond jc;
        t_step  tgt;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic dt_zero;
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic t_uword f_ucode(input t_step s);
        t_uword w;
        w = '{op: OP_NOP, msel: MS_ERR_DT, jc: JC_JUMP, tgt: 4'd0};
        unique case (s)
            4'd0:  w = '{op: OP_ACCEPT,    msel: MS_ERR_DT, jc: JC_WAIT_IN,  tgt: 4'd1};
            4'd1:  w = '{op: OP_ERR,       msel: MS_ERR_DT, jc: JC_NEXT,     tgt: 4'd0};
            4'd2:  w = '{op: OP_MUL,       msel: MS_ERR_DT, jc: JC_NEXT,     tgt: 4'd0};
            4'd3:  w = '{op: OP_INTEG,     msel: MS_ERR_DT, jc: JC_NEXT,     tgt: 4'd0};
            4'd4:  w = '{op: OP_MUL,       msel: MS_P,      jc: JC_NEXT,     tgt: 4'd0};
            4'd5:  w = '{op: OP_ACC_LOAD,  msel: MS_P,      jc: JC_NEXT,     tgt: 4'd0};
            4'd6:  w = '{op: OP_MUL,       msel: MS_I,      jc: JC_NEXT,     tgt: 4'd0};
            4'd7:  w = '{op: OP_ACC_ADD,   msel: MS_I,      jc: JC_NEXT,     tgt: 4'd0};
            4'd8:  w = '{op: OP_DIV_START, msel: MS_D,      jc: JC_DT_ZERO,  tgt: 4'd11};
            4'd9:  w = '{op: OP_NOP,       msel: MS_D,      jc: JC_DIV_BUSY, tgt: 4'd9};
            4'd10: w = '{op: OP_DIV_SIGN,  msel: MS_D,      jc: JC_NEXT,     tgt: 4'd0};
            4'd11: w = '{op: OP_MUL,       msel: MS_D,      jc: JC_NEXT,     tgt: 4'd0};
            4'd12: w = '{op: OP_ACC_ADD,   msel: MS_D,      jc: JC_NEXT,     tgt: 4'd0};
            4'd13: w = '{op: OP_OUT,       msel: MS_D,      jc: JC_WAIT_OUT, tgt: 4'd0};
            default: w = '{op: OP_NOP,     msel: MS_ERR_DT, jc: JC_JUMP,     tgt: 4'd0};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/pidaw_seq.sv @@
// Microcode sequencer: step counter, program ROM and jump logic.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_seq
    import pidaw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stat  i_stat,
    output t_uword o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;

    assign w_word = f_ucode(r_step);
    assign o_ctrl = w_word;

    always_comb begin
        n_step = r_step + 4'd1;
        unique case (w_word.jc)
            JC_NEXT:     n_step = r_step + 4'd1;
            JC_JUMP:     n_step = w_word.tgt;
            JC_WAIT_IN:  n_step = i_stat.in_fire ? w_word.tgt : r_step;
            JC_DT_ZERO:  n_step = i_stat.dt_zero ? w_word.tgt : r_step + 4'd1;
            JC_DIV_BUSY: n_step = i_stat.div_busy ? w_word.tgt : r_step + 4'd1;
            JC_WAIT_OUT: n_step = i_stat.out_free ? w_word.tgt : r_step;
            default:     n_step = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ hdl/pidaw_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_div
    import pidaw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [15:0]         i_divisor,
    output logic                o_busy,
    output logic [DIV_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [CNT_W-1:0]    r_cnt;
    logic [15:0]         r_rem;
    logic [DIV_BITS-1:0] r_q;
    logic [15:0]         r_dvs;
    logic [16:0]         w_trial;
    logic [17:0]         w_sub;

    assign w_trial    = {r_rem, r_q[DIV_BITS-1]};
    assign w_sub      = {1'b0, w_trial} - {2'b00, r_dvs};
    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_BITS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            if (!w_sub[17]) begin
                r_rem <= w_sub[15:0];
                r_q   <= {r_q[DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[15:0];
                r_q   <= {r_q[DIV_BITS-2:0], 1'b0};
            end
        end
    end

endmodule

@@ hdl/pidaw_datapath.sv @@
// Datapath: error and state registers, shared multiplier, integral clamp,
// sum and saturation, output register. Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_datapath
    import pidaw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_uword              i_ctrl,
    input  t_cfg                i_cfg,
    input  logic                i_in_fire,
    input  t_in_item            i_in_item,
    input  logic [DIV_BITS-1:0] i_quotient,
    output logic                o_div_start,
    output logic [DIV_BITS-1:0] o_dividend,
    output logic [15:0]         o_divisor,
    output logic                o_dt_zero,
    output logic                o_out_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item
);

    logic signed [16:0]   r_err;
    logic signed [16:0]   r_last;
    logic [15:0]          r_dt;
    logic signed [31:0]   r_integ;
    logic [DIV_BITS-1:0]  r_dvd;
    logic                 r_neg;
    logic signed [29:0]   r_deriv;
    logic signed [48:0]   r_prod;
    logic signed [41:0]   r_sum;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic signed [16:0]   w_ma;
    logic signed [31:0]   w_mb;
    logic signed [48:0]   w_mprod;
    logic signed [17:0]   w_diff;
    logic [17:0]          w_mag;
    logic signed [32:0]   w_acc;
    logic signed [32:0]   w_hi;
    logic signed [32:0]   w_lo;
    logic signed [32:0]   w_cl1;
    logic signed [32:0]   w_cl2;
    logic signed [41:0]   w_term;
    logic                 w_sat;
    logic signed [31:0]   w_drive;
    logic [29:0]          w_q30;

    always_comb begin
        w_ma = r_err;
        w_mb = $signed({16'b0, r_dt});
        case (i_ctrl.msel)
            MS_ERR_DT: begin
                w_ma = r_err;
                w_mb = $signed({16'b0, r_dt});
            end
            MS_P: begin
                w_ma = {i_cfg.gain_p[15], i_cfg.gain_p};
                w_mb = {{15{r_err[16]}}, r_err};
            end
            MS_I: begin
                w_ma = {i_cfg.gain_i[15], i_cfg.gain_i};
                w_mb = r_integ;
            end
            MS_D: begin
                w_ma = {i_cfg.gain_d[15], i_cfg.gain_d};
                w_mb = {{2{r_deriv[29]}}, r_deriv};
            end
            default: begin
                w_ma = r_err;
                w_mb = r_integ;
            end
        endcase
    end

    assign w_mprod = w_ma * w_mb;

    // error change magnitude for the divider
    assign w_diff = {r_err[16], r_err} - {r_last[16], r_last};
    assign w_mag  = w_diff[17] ? 18'(-w_diff) : w_diff;

    // integral update, high clamp first, then low
    assign w_acc = {r_integ[31], r_integ} + {{12{r_prod[32]}}, r_prod[32:12]};
    assign w_hi  = {i_cfg.lim_hi[31], i_cfg.lim_hi};
    assign w_lo  = {i_cfg.lim_lo[31], i_cfg.lim_lo};
    assign w_cl1 = (w_acc > w_hi) ? w_hi : w_acc;
    assign w_cl2 = (w_cl1 < w_lo) ? w_lo : w_cl1;

    assign w_term = {r_prod[48], r_prod[48:8]};

    assign w_sat   = !((&r_sum[41:31]) || !(|r_sum[41:31]));
    assign w_drive = !w_sat ? r_sum[31:0] : (r_sum[41] ? DRIVE_MIN : DRIVE_MAX);

    assign w_q30 = {1'b0, i_quotient};

    assign o_dt_zero   = (r_dt == '0);
    assign o_div_start = (i_ctrl.op == OP_DIV_START) && !o_dt_zero;
    assign o_dividend  = r_dvd;
    assign o_divisor   = r_dt;
    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // state values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            if (i_in_fire && i_in_item.restart) begin
                r_integ <= '0;
                r_last  <= '0;
            end
            if (i_ctrl.op == OP_ERR) begin
                r_last <= r_err;
            end
            if (i_ctrl.op == OP_INTEG) begin
                r_integ <= w_cl2[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_err <= {i_in_item.setpoint[15], i_in_item.setpoint}
                   - {i_in_item.measurement[15], i_in_item.measurement};
            r_dt  <= i_in_item.delta_time;
        end
        if (i_ctrl.op == OP_ERR) begin
            r_dvd   <= {w_mag[16:0], 12'b0};
            r_neg   <= w_diff[17];
            r_deriv <= '0;
        end
        if (i_ctrl.op == OP_DIV_SIGN) begin
            r_deriv <= r_neg ? $signed(-w_q30) : $signed(w_q30);
        end
        if (i_ctrl.op == OP_MUL) begin
            r_prod <= w_mprod;
        end
        if (i_ctrl.op == OP_ACC_LOAD) begin
            r_sum <= w_term;
        end else if (i_ctrl.op == OP_ACC_ADD) begin
            r_sum <= r_sum + w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == OP_OUT && o_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_OUT && o_out_free) begin
            r_out_item.drive     <= w_drive;
            r_out_item.saturated <= w_sat;
        end
    end

endmodule

@@ hdl/pid_controller_anti_windup.sv @@
// PID controller with integral clamp: sample-by-sample fixed-point loop.
// Top level; depends on pidaw_pkg, pidaw_seq, pidaw_datapath, pidaw_div
// and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) takes one sample item:
//   setpoint, measurement, time step and restart bit. Output channel
//   (o_out_valid/i_out_ready, o_out_item) returns one drive item per sample.
//   Config channel (i_cfg_valid/o_cfg_ready) writes gains and integral
//   limits by index; ready whenever out of reset, unknown indexes are
//   ignored. Write only while idle.
//   With a zero time step the sequencer skips the 29-step serial divider
//   for the derivative, whose term is then zero. One item at a time: a
//   new sample is accepted only once the last one's result is written to
//   the output register.
//   The result sits in an output register; the next item is accepted while
//   it waits, and the sequencer holds at its last step until the register
//   frees. A stall downstream therefore stalls the input after one item.
//   Reset clears the integral and previous error, loads default gains (0)
//   and limits (-100.0 / +100.0) and leaves the output empty.
`timescale 1ns / 1ps
`include "pid_controller_anti_windup_defines.svh"

module pid_controller_anti_windup
    import pidaw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg                r_cfg;
    t_uword              w_ctrl;
    t_stat               w_stat;
    logic                w_in_fire;
    logic                w_div_start;
    logic                w_div_busy;
    logic [DIV_BITS-1:0] w_dividend;
    logic [DIV_BITS-1:0] w_quotient;
    logic [15:0]         w_divisor;
    logic                w_dt_zero;
    logic                w_out_free;

    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && (w_ctrl.op == OP_ACCEPT);
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign w_stat.in_fire  = w_in_fire;
    assign w_stat.dt_zero  = w_dt_zero;
    assign w_stat.div_busy = w_div_busy;
    assign w_stat.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p <= '0;
            r_cfg.gain_i <= '0;
            r_cfg.gain_d <= '0;
            r_cfg.lim_lo <= LIM_LO_RESET;
            r_cfg.lim_hi <= LIM_HI_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GAIN_P: r_cfg.gain_p <= i_cfg_data[15:0];
                REG_GAIN_I: r_cfg.gain_i <= i_cfg_data[15:0];
                REG_GAIN_D: r_cfg.gain_d <= i_cfg_data[15:0];
                REG_LIM_LO: r_cfg.lim_lo <= i_cfg_data;
                REG_LIM_HI: r_cfg.lim_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pidaw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    pidaw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg       (r_cfg),
        .i_in_fire   (w_in_fire),
        .i_in_item   (i_in_item),
        .i_quotient  (w_quotient),
        .o_div_start (w_div_start),
        .o_dividend  (w_dividend),
        .o_divisor   (w_divisor),
        .o_dt_zero   (w_dt_zero),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    pidaw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    `PIDAW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !o_in_ready)
    `PIDAW_ASSERT_NOW(a_div_only_in_wait, i_clk, i_rst_n, w_div_busy, w_ctrl.op == OP_NOP)
    `PIDAW_ASSERT_NOW(a_sat_at_rail, i_clk, i_rst_n, o_out_valid && o_out_item.saturated, (o_out_item.drive == DRIVE_MAX) || (o_out_item.drive == DRIVE_MIN))

endmodule
